/* hw/rtl/rule110_strip_generation_macros.svh */
// Assertion macros used by the checker file.
`ifndef RULE110_STRIP_GENERATION_MACROS_SVH
`define RULE110_STRIP_GENERATION_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define R110_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define R110_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/r110sg_pkg.sv */
package r110sg_pkg;

    // Strip size default
    localparam int CELL_COUNT_DEF = 64;

    // Field widths
    localparam int RAND_W     = 64;
    localparam int CELL_IDX_W = 6;
    localparam int HUE_W      = 10;
    localparam int GEN_W      = 16;
    localparam int ACT_W      = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Hue divider: dividend is count * 4
    localparam int DVD_W       = GEN_W + 2;
    localparam int DIV_CNT_W   = 5;
    localparam int DIV_STEPS   = DVD_W;

    // Rule 110 truth table, indexed by {left, self, right}
    localparam logic [7:0] RULE_BITS = 8'd110;

    // Register reset values
    localparam logic [GEN_W-1:0] RESEED_PERIOD_RST = 16'd256;
    localparam logic [HUE_W-1:0] WHEEL_MAX_RST     = 10'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESEED_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MAX     = 1'b1;

    // Colour actions
    typedef enum logic [ACT_W-1:0] {
        ACT_KEEP   = 2'd0,
        ACT_HUE    = 2'd1,
        ACT_DARKEN = 2'd2,
        ACT_OFF    = 2'd3
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic cell_last;
        logic out_free;
    } status_t;

endpackage

/* hw/rtl/r110sg_ctrl.sv */
module r110sg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  r110sg_pkg::status_t status,
    output r110sg_pkg::cmd_t    cmd
);

    r110sg_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= r110sg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            r110sg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = r110sg_pkg::ST_DIV;
                end
            end
            r110sg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = r110sg_pkg::ST_EMIT;
                end
            end
            r110sg_pkg::ST_EMIT: begin
                // one cell per free output slot
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.cell_last) begin
                        cmd.finish = 1'b1;
                        state_next = r110sg_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = r110sg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/r110sg_dpath.sv */
module r110sg_dpath #(
    parameter int CELL_COUNT = r110sg_pkg::CELL_COUNT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [r110sg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [r110sg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [r110sg_pkg::RAND_W-1:0]        random_bits,
    input  r110sg_pkg::cmd_t                     cmd,
    output r110sg_pkg::status_t                  status,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [r110sg_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                 m_tlast
);

    localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int HW = r110sg_pkg::HUE_W;
    localparam int GW = r110sg_pkg::GEN_W;
    localparam int DW = r110sg_pkg::DVD_W;
    localparam int CW = r110sg_pkg::DIV_CNT_W;

    // Configuration registers
    logic [GW-1:0] reseed_period_reg;
    logic [HW-1:0] wheel_max_reg;

    // Generation state
    logic [GW-1:0] gen_count_reg, gen_count_next;
    logic [HW-1:0] hue_reg;
    logic          reseed_reg;

    // Cell shift line, left neighbour and index
    logic [CELL_COUNT-1:0] cells_reg;
    logic [CELL_COUNT:0]   cells_ext;
    logic                  left_reg;
    logic [IDX_W-1:0]      idx_reg;

    // Hue divider
    logic [HW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvd_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [HW:0]   trial;

    // Output register
    logic                            out_valid_reg;
    logic [r110sg_pkg::CELL_IDX_W-1:0] out_index_reg;
    logic                            out_alive_reg;
    r110sg_pkg::action_t             out_action_reg;
    logic [HW-1:0]                   out_hue_reg;
    logic                            out_last_reg;

    // Cell evaluation
    logic                self_bit, right_bit, new_bit;
    logic [2:0]          pat;
    r110sg_pkg::action_t act;
    logic [GW:0]         count_inc;

    assign cells_ext = {1'b1, cells_reg};
    assign self_bit  = cells_reg[0];
    assign right_bit = status.cell_last ? 1'b1 : cells_ext[1];
    assign pat       = {left_reg, self_bit, right_bit};

    always_comb begin
        if (reseed_reg) begin
            new_bit = self_bit;
            act     = self_bit ? r110sg_pkg::ACT_HUE : r110sg_pkg::ACT_OFF;
        end else begin
            new_bit = r110sg_pkg::RULE_BITS[pat];
            case (pat)
                3'b101, 3'b001:         act = r110sg_pkg::ACT_HUE;
                3'b111, 3'b100, 3'b000: act = r110sg_pkg::ACT_DARKEN;
                default:                act = r110sg_pkg::ACT_KEEP;
            endcase
        end
    end

    // Restoring divide step: one dividend bit a cycle
    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign rem_next = (trial >= {1'b0, wheel_max_reg})
                    ? HW'(trial - {1'b0, wheel_max_reg}) : HW'(trial);

    // Count wraps at the reseed period
    assign count_inc      = {1'b0, gen_count_reg} + (GW+1)'(1);
    assign gen_count_next = (count_inc >= {1'b0, reseed_period_reg}) ? '0 : count_inc[GW-1:0];

    assign status.div_done  = (div_cnt_reg == CW'(r110sg_pkg::DIV_STEPS - 1));
    assign status.cell_last = (idx_reg == IDX_W'(CELL_COUNT - 1));
    assign status.out_free  = !out_valid_reg || m_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reseed_period_reg <= r110sg_pkg::RESEED_PERIOD_RST;
            wheel_max_reg     <= r110sg_pkg::WHEEL_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                r110sg_pkg::CFG_RESEED_PERIOD: reseed_period_reg <= cfg_wdata[GW-1:0];
                r110sg_pkg::CFG_WHEEL_MAX:     wheel_max_reg     <= cfg_wdata[HW-1:0];
                default: ;
            endcase
        end
    end

    // Generation count and hue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_count_reg <= '0;
            hue_reg       <= '0;
            reseed_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                reseed_reg <= (gen_count_reg == '0);
            end
            if (cmd.div_step && status.div_done) begin
                hue_reg <= (reseed_reg || wheel_max_reg == '0) ? '0 : rem_next;
            end
            if (cmd.finish) begin
                gen_count_reg <= gen_count_next;
            end
        end
    end

    // Divider registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg     <= '0;
            dvd_reg     <= {gen_count_reg, 2'b00};
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            dvd_reg     <= {dvd_reg[DW-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + CW'(1);
        end
    end

    // Cell line: new states shift in at the top as old ones leave at the bottom
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (gen_count_reg == '0) begin
                cells_reg <= random_bits[CELL_COUNT-1:0];
            end
            left_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (cmd.emit) begin
            cells_reg <= CELL_COUNT'({new_bit, cells_reg} >> 1);
            left_reg  <= self_bit;
            idx_reg   <= idx_reg + IDX_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_index_reg  <= r110sg_pkg::CELL_IDX_W'(idx_reg);
            out_alive_reg  <= new_bit;
            out_action_reg <= act;
            out_hue_reg    <= (act == r110sg_pkg::ACT_HUE) ? hue_reg : '0;
            out_last_reg   <= status.cell_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_hue_reg, out_action_reg, out_alive_reg, out_index_reg};

endmodule

/* hw/rtl/rule110_strip_generation.sv */
// After an item is accepted, the 18-step hue divider runs before the first result beat.
// Items go one at a time: s_tready is high only in idle, once the last cell is emitted;
//   results leave one cell a cycle while m_tready is high, via the single output register.
// Reset: aresetn, synchronous, active low; generation count and hue clear to zero,
//   registers take 256 / 256, so the first item after reset always reseeds the strip.
module rule110_strip_generation #(
    parameter int CELL_COUNT = r110sg_pkg::CELL_COUNT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [r110sg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [r110sg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input beats
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [r110sg_pkg::RAND_W-1:0]        s_tdata,   // [63:0] random_bits
    // result beats
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [r110sg_pkg::OUT_DATA_W-1:0]    m_tdata,   // [5:0] cell_index, [6] alive,
                                                            // [8:7] color_action, [18:9] hue
    output logic                                 m_tlast
);

    r110sg_pkg::cmd_t    cmd;
    r110sg_pkg::status_t status;

    r110sg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    r110sg_dpath #(
        .CELL_COUNT (CELL_COUNT)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .random_bits (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

/* hw/rtl/r110sg_checker.sv */
`include "rule110_strip_generation_macros.svh"

module r110sg_checker #(
    parameter int CELL_COUNT = r110sg_pkg::CELL_COUNT_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [r110sg_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                                 m_tlast
);

    // Result beat fields
    logic [r110sg_pkg::CELL_IDX_W-1:0] f_index;
    logic                              f_alive;
    logic [r110sg_pkg::ACT_W-1:0]      f_action;
    logic [r110sg_pkg::HUE_W-1:0]      f_hue;

    // Handshake and expectation terms
    logic [r110sg_pkg::OUT_DATA_W:0]   beat;
    logic                              out_stall;
    logic                              in_take;
    logic                              no_hue;
    logic                              alive_want;
    logic                              last_want;

    assign f_index  = m_tdata[5:0];
    assign f_alive  = m_tdata[6];
    assign f_action = m_tdata[8:7];
    assign f_hue    = m_tdata[18:9];

    assign beat       = {m_tlast, m_tdata};
    assign out_stall  = m_tvalid && !m_tready;
    assign in_take    = s_tvalid && s_tready;
    assign no_hue     = m_tvalid && (f_action != r110sg_pkg::ACT_HUE);
    // keep and set-to-hue leave the cell alive, darken and off leave it dead
    assign alive_want = (f_action == r110sg_pkg::ACT_KEEP) || (f_action == r110sg_pkg::ACT_HUE);
    assign last_want  = (f_index == r110sg_pkg::CELL_IDX_W'(CELL_COUNT - 1));

    // A stalled result beat holds
    `R110_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(beat), "beat moved")

    // One item at a time: no second input beat straight after one is taken
    `R110_ASSERT_NEXT(a_in_busy, aclk, aresetn, in_take, !s_tready, "input taken while busy")

    // Hue only travels with the set-to-hue action
    `R110_ASSERT_NOW(a_hue_zero, aclk, aresetn, no_hue, f_hue == '0, "hue without set-to-hue")

    // Alive bit agrees with the colour action
    `R110_ASSERT_NOW(a_alive_act, aclk, aresetn, m_tvalid, f_alive == alive_want, "alive vs action")

    // Last beat of a tick is the final cell
    `R110_ASSERT_NOW(a_last_idx, aclk, aresetn, m_tvalid, m_tlast == last_want, "tlast misplaced")

endmodule

bind rule110_strip_generation r110sg_checker #(.CELL_COUNT(CELL_COUNT)) u_r110sg_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import r110sg_pkg::*;

    localparam int STRIP_LEN      = CELL_COUNT_DEF;
    localparam int SETTLE_CYCLES  = 40;     // > first-beat latency of the hue divider
    localparam int LONG_HOLD      = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam logic [7:0] RULE110 = 8'b0110_1110;

    // Expected result beat, one per strip position
    typedef struct packed {
        logic [CELL_IDX_W-1:0] idx;
        logic                  alive;
        action_t               act;
        logic [HUE_W-1:0]      hue;
        logic                  last;
    } cell_beat_t;

    // Directed plan rows
    typedef enum logic [1:0] {
        ROW_REG,        // register write while idle
        ROW_SEED,       // item checked against the predictor
        ROW_TYPED       // item with the strip outcome written out by hand
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [RAND_W-1:0]     seed;
        logic [RAND_W-1:0]     alive_mask;
        action_t               alive_act;
        action_t               dead_act;
        logic [HUE_W-1:0]      hue;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RAND_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    rule110_strip_generation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state
    logic [STRIP_LEN-1:0]  strip_now;
    logic [GEN_W-1:0]      gen_count;
    logic [GEN_W-1:0]      reseed_period;
    logic [HUE_W-1:0]      hue_wrap;

    cell_beat_t            pending_cells[$];
    plan_row_t             plan[$];

    int  mismatches    = 0;
    int  beats_checked = 0;
    int  ticks_sent    = 0;
    int  reseed_ticks  = 0;
    int  reg_writes    = 0;
    int  holds_done    = 0;
    bit  rx_hold_req   = 1'b0;
    bit  sender_calm   = 1'b0;

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] beat %0d %s: got %0d, want %0d", $realtime, beats_checked,
                 field, got, want);
        mismatches++;
    endtask

    // One generation of the strip: reseed on count zero, else Rule 110 step
    function automatic void predict_tick(input logic [RAND_W-1:0] seed,
                                         output cell_beat_t beats [STRIP_LEN]);
        logic [STRIP_LEN-1:0] next_strip;
        logic [2:0]           nbhd;
        logic                 lft, rgt;
        int unsigned          tick_hue;
        logic [GEN_W:0]       count_up;
        tick_hue = 0;
        if (gen_count == '0) begin
            reseed_ticks++;
            for (int i = 0; i < STRIP_LEN; i++) begin
                next_strip[i]  = seed[i];
                beats[i].idx   = CELL_IDX_W'(i);
                beats[i].alive = seed[i];
                beats[i].act   = seed[i] ? ACT_HUE : ACT_OFF;
                beats[i].hue   = '0;
                beats[i].last  = (i == STRIP_LEN - 1);
            end
        end else begin
            if (hue_wrap != '0)
                tick_hue = (32'(gen_count) * 4) % 32'(hue_wrap);
            for (int i = 0; i < STRIP_LEN; i++) begin
                // ends of the strip read as alive
                lft  = (i == 0) ? 1'b1 : strip_now[i-1];
                rgt  = (i == STRIP_LEN - 1) ? 1'b1 : strip_now[i+1];
                nbhd = {lft, strip_now[i], rgt};
                next_strip[i]  = RULE110[nbhd];
                beats[i].idx   = CELL_IDX_W'(i);
                beats[i].alive = RULE110[nbhd];
                case (nbhd)
                    3'b101, 3'b001:         beats[i].act = ACT_HUE;
                    3'b111, 3'b100, 3'b000: beats[i].act = ACT_DARKEN;
                    default:                beats[i].act = ACT_KEEP;
                endcase
                beats[i].hue   = (beats[i].act == ACT_HUE) ? HUE_W'(tick_hue) : '0;
                beats[i].last  = (i == STRIP_LEN - 1);
            end
        end
        strip_now = next_strip;
        count_up  = {1'b0, gen_count} + 1'b1;
        gen_count = (count_up >= {1'b0, reseed_period}) ? '0 : count_up[GEN_W-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 93)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [RAND_W-1:0] pick_seed();
        logic [RAND_W-1:0] one_hot;
        one_hot = RAND_W'(1) << $urandom_range(0, RAND_W - 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one seed beat, hold until taken, then queue what it should produce
    task automatic send_tick(input logic [RAND_W-1:0] seed, input bit typed,
                             input logic [RAND_W-1:0] alive_mask, input action_t alive_act,
                             input action_t dead_act, input logic [HUE_W-1:0] hue);
        cell_beat_t beats [STRIP_LEN];
        cell_beat_t hand;
        int         gap;
        s_tvalid <= 1'b1;
        s_tdata  <= seed;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tick(seed, beats);
        ticks_sent++;
        for (int i = 0; i < STRIP_LEN; i++) begin
            if (typed) begin
                hand.idx   = CELL_IDX_W'(i);
                hand.alive = alive_mask[i];
                hand.act   = alive_mask[i] ? alive_act : dead_act;
                hand.hue   = (hand.act == ACT_HUE) ? hue : '0;
                hand.last  = (i == STRIP_LEN - 1);
                pending_cells.push_back(hand);
            end else begin
                pending_cells.push_back(beats[i]);
            end
        end
        // sender gaps come and go in stretches
        if ($urandom_range(0, 19) == 0)
            sender_calm = ~sender_calm;
        gap = (sender_calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every queued result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_RESEED_PERIOD)
            reseed_period = val;
        else
            hue_wrap = val[HUE_W-1:0];
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: check each beat, stall at random, one long hold on request
    initial begin : result_sink
        cell_beat_t want;
        int         stall_left;
        int         rx_cycle;
        bit         rx_calm;
        stall_left = 0;
        rx_cycle   = 0;
        rx_calm    = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_cells.size() == 0) begin
                    report_mismatch("unexpected beat, cell", m_tdata[5:0], 0);
                end else begin
                    want = pending_cells.pop_front();
                    if (m_tdata[5:0] != want.idx)
                        report_mismatch("cell_index", m_tdata[5:0], want.idx);
                    if (m_tdata[6] != want.alive)
                        report_mismatch("alive", m_tdata[6], want.alive);
                    if (m_tdata[8:7] != want.act)
                        report_mismatch("color_action", m_tdata[8:7], want.act);
                    if (m_tdata[18:9] != want.hue)
                        report_mismatch("hue", m_tdata[18:9], want.hue);
                    if (m_tdata[23:19] != '0)
                        report_mismatch("tdata padding", m_tdata[23:19], 0);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
                beats_checked++;
            end
            rx_cycle++;
            if (rx_cycle % 300 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (stall_left == 0 && rx_hold_req) begin
                stall_left  = LONG_HOLD;
                rx_hold_req = 1'b0;
                holds_done++;
            end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap_len();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a beat on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat for %0d cycles, %0d results outstanding", quiet,
                 pending_cells.size());
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial begin : seed_source
        int n_items;
        int rc_val;
        int wm_val;
        // predictor matches the reset values
        strip_now     = '0;
        gen_count     = '0;
        reseed_period = RESEED_PERIOD_RST;
        hue_wrap      = WHEEL_MAX_RST;

        // Directed plan, starting from reset (period 256, wheel 256)
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, '1, '1,
                         ACT_HUE, ACT_OFF, 10'd0});
        // all alive advances to all 111 neighbourhoods; seed is ignored
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, 64'h0123_4567_89AB_CDEF, '0,
                         ACT_KEEP, ACT_DARKEN, 10'd0});
        // all dead: only the last cell sees a live right edge, hue = 2 * 4
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, '1, 64'h8000_0000_0000_0000,
                         ACT_HUE, ACT_DARKEN, 10'd8});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '1, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        // period dropped below the running count: one more advance, then wrap
        plan.push_back('{ROW_REG, CFG_RESEED_PERIOD, 16'd1, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, 64'hDEAD_BEEF_0BAD_F00D, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        // period one: every tick reseeds
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_HUE, ACT_OFF, 10'd0});
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, 64'hAAAA_AAAA_AAAA_AAAA,
                         64'hAAAA_AAAA_AAAA_AAAA, ACT_HUE, ACT_OFF, 10'd0});
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, 64'h5555_5555_5555_5555,
                         64'h5555_5555_5555_5555, ACT_HUE, ACT_OFF, 10'd0});
        // period zero also reseeds every tick
        plan.push_back('{ROW_REG, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, 64'h8000_0000_0000_0001,
                         64'h8000_0000_0000_0001, ACT_HUE, ACT_OFF, 10'd0});
        // longest period, zero wheel: hue stays 0
        plan.push_back('{ROW_REG, CFG_RESEED_PERIOD, 16'hFFFF, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_REG, CFG_WHEEL_MAX, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_TYPED, CFG_RESEED_PERIOD, 16'd0, 64'h0F0F_0F0F_F0F0_F0F0,
                         64'h0F0F_0F0F_F0F0_F0F0, ACT_HUE, ACT_OFF, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        // wheels below the hue step, then the widest wheel
        plan.push_back('{ROW_REG, CFG_WHEEL_MAX, 16'd1, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_REG, CFG_WHEEL_MAX, 16'd3, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_REG, CFG_WHEEL_MAX, 16'd1023, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});
        plan.push_back('{ROW_SEED, CFG_RESEED_PERIOD, 16'd0, '0, '0,
                         ACT_KEEP, ACT_KEEP, 10'd0});

        // Reset
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                drain_results();
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                send_tick(plan[r].seed, plan[r].kind == ROW_TYPED, plan[r].alive_mask,
                          plan[r].alive_act, plan[r].dead_act, plan[r].hue);
            end
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 7; ph++) begin
            drain_results();
            case (ph)
                0: begin rc_val = 3;     wm_val = 1023; n_items = 30;  end
                1: begin rc_val = 65535; wm_val = 4;    n_items = 25;  end
                // long run so the hue climbs through its upper bits
                2: begin rc_val = 300;   wm_val = 1023; n_items = 170; end
                // period well under the running count
                3: begin rc_val = 5;     wm_val = $urandom_range(4, 1023); n_items = 30; end
                4: begin
                    rc_val = $urandom_range(1, 16); wm_val = $urandom_range(0, 1023);
                    n_items = 25;
                end
                5: begin rc_val = 1;     wm_val = 0;    n_items = 15;  end
                default: begin
                    rc_val = $urandom_range(2, 40); wm_val = $urandom_range(4, 1023);
                    n_items = 25;
                end
            endcase
            write_reg(CFG_RESEED_PERIOD, CFG_DATA_W'(rc_val));
            // upper write-data bits are don't-care for the 10-bit wheel
            write_reg(CFG_WHEEL_MAX, {6'($urandom), HUE_W'(wm_val)});
            if (ph == 0) begin
                // back-to-back offers against a long receiver hold
                sender_calm = 1'b1;
                rx_hold_req = 1'b1;
            end
            for (int k = 0; k < n_items; k++) begin
                send_tick(pick_seed(), 1'b0, '0, ACT_KEEP, ACT_KEEP, '0);
                if (ph != 0 && $urandom_range(0, 39) == 0)
                    drain_results();
            end
            if (ph == 0)
                sender_calm = 1'b0;
        end

        // Wind down
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("ran %0d generations (%0d reseeds), %0d result beats checked",
                 ticks_sent, reseed_ticks, beats_checked);
        $display("%0d register writes, %0d long receiver hold(s), %0d mismatches",
                 reg_writes, holds_done, mismatches);
        if (mismatches == 0 && pending_cells.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
